// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/lcdseq_pkg.sv =====
// Types, constants and byte decode functions for the LCD nibble command sequencer
`default_nettype none

package lcdseq_pkg;

	localparam int MAX_POSITION_DEF = 32;
	localparam int MAX_SCROLL_DEF   = 31;
	localparam int CNT_W            = 6;
	localparam int IDX_W            = 5;
	localparam int WAIT_W           = 13;

	localparam logic [WAIT_W-1:0] WAIT_HIGH  = 13'd10;
	localparam logic [WAIT_W-1:0] WAIT_LOW   = 13'd50;
	localparam logic [WAIT_W-1:0] WAIT_CLEAR = 13'd5000;
	localparam logic [WAIT_W-1:0] WAIT_HOME  = 13'd3000;
	localparam logic [WAIT_W-1:0] WAIT_NONE  = 13'd0;

	localparam logic [7:0] CMD_FUNCSET = 8'h28;
	localparam logic [7:0] CMD_DISPON  = 8'h0C;
	localparam logic [7:0] CMD_CURSON  = 8'h0E;
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_HOME    = 8'h02;
	localparam logic [7:0] CMD_RIGHT   = 8'h14;
	localparam logic [7:0] CMD_SCROLL  = 8'h18;
	localparam logic [7:0] DEGREE_IN   = 8'hB0;
	localparam logic [7:0] DEGREE_OUT  = 8'hDF;

	typedef enum logic [2:0] {
		MODE_RAW    = 3'd0,
		MODE_CHAR   = 3'd1,
		MODE_CLEAR  = 3'd2,
		MODE_HOME   = 3'd3,
		MODE_CURSOR = 3'd4,
		MODE_SETPOS = 3'd5,
		MODE_SCROLL = 3'd6,
		MODE_INIT   = 3'd7
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic       rs;
		logic [7:0] value;
		logic       flag;
	} cmd_item_t;

	typedef struct packed {
		logic              sel;
		logic [3:0]        nibble;
		logic [WAIT_W-1:0] wait_us;
		logic              last;
	} xfer_item_t;

	function automatic logic [7:0] xfer_byte(mode_t m, logic [IDX_W-1:0] idx,
			logic [7:0] data, logic flag);
		logic [7:0] b;
		b = data;
		unique case (m)
			MODE_RAW, MODE_CHAR, MODE_CURSOR: b = data;
			MODE_CLEAR:  b = CMD_CLEAR;
			MODE_HOME:   b = CMD_HOME;
			MODE_SETPOS: b = (idx == '0) ? CMD_HOME : CMD_RIGHT;
			MODE_SCROLL: b = CMD_SCROLL | {5'd0, flag, 2'd0};
			MODE_INIT: begin
				unique case (idx[1:0])
					2'd0: b = CMD_FUNCSET;
					2'd1: b = CMD_DISPON;
					2'd2: b = CMD_CLEAR;
					2'd3: b = CMD_HOME;
					default: b = CMD_HOME;
				endcase
			end
			default: b = data;
		endcase
		return b;
	endfunction

	function automatic logic [WAIT_W-1:0] xfer_extra(mode_t m, logic [IDX_W-1:0] idx);
		logic [WAIT_W-1:0] w;
		w = WAIT_NONE;
		unique case (m)
			MODE_CLEAR:  w = WAIT_CLEAR;
			MODE_HOME:   w = WAIT_HOME;
			MODE_SETPOS: w = (idx == '0) ? WAIT_HOME : WAIT_NONE;
			MODE_INIT: begin
				if (idx[1:0] == 2'd2) begin
					w = WAIT_CLEAR;
				end else if (idx[1:0] == 2'd3) begin
					w = WAIT_HOME;
				end
			end
			default: w = WAIT_NONE;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/char_lcd_nibble_command_sequencer.sv =====
// LCD command to 4-bit nibble transfer sequencer, top level
// After a command is accepted, the sequencer enters ST_RUN and then registers the first transfer.
// Throughput: one transfer per cycle without stalls; a command of n bytes gives 2n transfers
// (at most 64), paced by the byte index and nibble toggle, and stalls the input until the final one is registered.
// The next command is taken the cycle after the final transfer enters the output register.
// Reset (arst_n low, asynchronous): sequencer idle, no transfer pending.
`default_nettype none
`include "assert_macros.svh"

module char_lcd_nibble_command_sequencer #(
	parameter int MAX_POSITION = lcdseq_pkg::MAX_POSITION_DEF,
	parameter int MAX_SCROLL   = lcdseq_pkg::MAX_SCROLL_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cmd_valid,
	output logic                   cmd_stall,
	input  lcdseq_pkg::cmd_item_t  cmd,
	output logic                   xfer_valid,
	input  wire                    xfer_stall,
	output lcdseq_pkg::xfer_item_t xfer
);
	import lcdseq_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t            state_q;
	mode_t             mode_q;
	logic              sel_q;
	logic [7:0]        data_q;
	logic              flag_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic              half_q;
	logic              xfer_valid_q;
	xfer_item_t        xfer_q;

	logic              accept;
	logic              advance;
	logic              last_byte;
	logic [7:0]        cur_byte;
	logic [WAIT_W-1:0] low_wait;
	logic [CNT_W-1:0]  new_cnt;
	logic [7:0]        new_data;
	logic              new_sel;

	assign cmd_stall  = (state_q == ST_RUN);
	assign accept     = cmd_valid && !cmd_stall;
	assign advance    = (state_q == ST_RUN) && (!xfer_valid_q || !xfer_stall);
	assign last_byte  = ({1'b0, idx_q} == (cnt_q - CNT_W'(1)));
	assign cur_byte   = xfer_byte(mode_q, idx_q, data_q, flag_q);
	assign low_wait   = WAIT_LOW + xfer_extra(mode_q, idx_q);
	assign xfer_valid = xfer_valid_q;
	assign xfer       = xfer_q;

	always_comb begin
		new_cnt  = CNT_W'(1);
		new_data = cmd.value;
		new_sel  = 1'b0;
		unique case (cmd.mode)
			MODE_RAW: begin
				new_sel = cmd.rs;
			end
			MODE_CHAR: begin
				new_sel  = 1'b1;
				new_data = (cmd.value == DEGREE_IN) ? DEGREE_OUT : cmd.value;
			end
			MODE_CURSOR: begin
				new_data = cmd.flag ? CMD_CURSON : CMD_DISPON;
			end
			MODE_SETPOS: begin
				if (cmd.value > 8'(MAX_POSITION)) begin
					new_cnt = CNT_W'(MAX_POSITION);
				end else if (cmd.value == 8'd0) begin
					new_cnt = CNT_W'(1);
				end else begin
					new_cnt = cmd.value[CNT_W-1:0];
				end
			end
			MODE_SCROLL: begin
				if (cmd.value > 8'(MAX_SCROLL)) begin
					new_cnt = CNT_W'(MAX_SCROLL);
				end else begin
					new_cnt = cmd.value[CNT_W-1:0];
				end
			end
			MODE_INIT: begin
				new_cnt = CNT_W'(4);
			end
			default: begin
				new_cnt = CNT_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_RAW;
			sel_q        <= 1'b0;
			data_q       <= '0;
			flag_q       <= 1'b0;
			cnt_q        <= '0;
			idx_q        <= '0;
			half_q       <= 1'b0;
			xfer_valid_q <= 1'b0;
			xfer_q       <= '0;
		end else begin
			if (xfer_valid_q && !xfer_stall && !advance) begin
				xfer_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= cmd.mode;
						sel_q  <= new_sel;
						data_q <= new_data;
						flag_q <= cmd.flag;
						cnt_q  <= new_cnt;
						idx_q  <= '0;
						half_q <= 1'b0;
						if (new_cnt != '0) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (advance) begin
						xfer_valid_q   <= 1'b1;
						xfer_q.sel     <= sel_q;
						xfer_q.nibble  <= half_q ? cur_byte[3:0] : cur_byte[7:4];
						xfer_q.wait_us <= half_q ? low_wait : WAIT_HIGH;
						xfer_q.last    <= half_q && last_byte;
						half_q         <= !half_q;
						if (half_q) begin
							if (last_byte) begin
								state_q <= ST_IDLE;
							end else begin
								idx_q <= idx_q + IDX_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMP(a_last_is_low_nibble, clk, arst_n, xfer_valid && xfer.last, xfer.wait_us != WAIT_HIGH)
	`ASSERT_IMP(a_idx_in_range, clk, arst_n, state_q == ST_RUN, {1'b0, idx_q} < cnt_q)
	`ASSERT_NXT(a_cmd_starts_run, clk, arst_n, accept && !(cmd.mode == MODE_SCROLL && cmd.value == 8'd0), state_q == ST_RUN)

endmodule

`default_nettype wire
